// ===== hw/rtl/i2cm_pkg.sv =====
// ============================================================================
// I2C master sequencer package
// Shared types, codes, the bus operation table and the per-phase pin action.
// ============================================================================
package i2cm_pkg;

    // Command codes carried in the request.
    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ_ACK  = 3'd3,
        CMD_READ_NACK = 3'd4,
        CMD_REG_WRITE = 3'd5,
        CMD_REG_READ  = 3'd6
    } cmd_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_RESTART = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    // Operation table row used by a register read that stops before restart.
    localparam logic [2:0] ROW_REG_READ_STOP = 3'd7;
    localparam logic [2:0] STAGE_LAST        = 3'd7;

    // Phase counts of the bus operations.
    localparam logic [4:0] START_STEPS = 5'd4;
    localparam logic [4:0] STOP_STEPS  = 5'd3;
    localparam logic [4:0] BYTE_STEPS  = 5'd18;
    localparam logic [3:0] ACK_BIT     = 4'd8;

    localparam logic [7:0] MSB_MASK  = 8'h80;
    localparam logic [7:0] READ_FLAG = 8'h01;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_kind_t;

    typedef enum logic [1:0] {
        SRC_DATA   = 2'd0,
        SRC_ADDR_W = 2'd1,
        SRC_REG    = 2'd2,
        SRC_ADDR_R = 2'd3
    } src_t;

    typedef struct packed {
        op_kind_t kind;
        src_t     src;
    } op_t;

    typedef struct packed {
        logic scl;
        logic scl_en;
        logic sda;
        logic sda_en;
    } pins_t;

    typedef struct packed {
        pins_t      pins;
        logic [7:0] shift;
        logic       nack;
        logic [7:0] rx;
    } dp_t;

    typedef struct packed {
        logic        active;
        logic [2:0]  acmd;
        logic [6:0]  addr;
        logic [7:0]  reg_idx;
        logic [7:0]  data;
        logic [2:0]  stage;
        logic [4:0]  step;
        logic [15:0] tick;
        dp_t         dp;
    } seq_t;

    localparam seq_t SEQ_RESET = '{
        active:  1'b0,
        acmd:    3'd0,
        addr:    7'd0,
        reg_idx: 8'd0,
        data:    8'd0,
        stage:   3'd0,
        step:    5'd0,
        tick:    16'd0,
        dp:      '{pins: '{scl: 1'b1, scl_en: 1'b0, sda: 1'b1, sda_en: 1'b0},
                   shift: 8'd0, nack: 1'b0, rx: 8'd0}
    };

    typedef struct packed {
        logic        req_type;
        logic [2:0]  command;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_index;
        logic [7:0]  data_byte;
        logic        sda_in;
    } req_t;

    typedef struct packed {
        logic        scl_out;
        logic        scl_enable;
        logic        sda_out;
        logic        sda_enable;
        logic        busy_res;
        logic        done_res;
        logic        nack_seen;
        logic [7:0]  rx_byte;
        logic        rejected;
    } res_t;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic        stop_before_restart;
    } cfg_t;

    // Table row for a command; a register read with STOP before restart
    // uses its own row.
    function automatic logic [2:0] i2cm_row(logic [2:0] cmd, logic sbr);
        logic [2:0] row;
        row = cmd;
        if (cmd == CMD_REG_READ && sbr)
        begin
            row = ROW_REG_READ_STOP;
        end
        return row;
    endfunction

    // Bus operation list of each command.
    function automatic op_t i2cm_op_at(logic [2:0] row, logic [2:0] stage);
        op_t op;
        op = '{kind: OP_NONE, src: SRC_DATA};
        case (row)
            CMD_START:
            begin
                if (stage == 3'd0) op = '{kind: OP_START, src: SRC_DATA};
            end
            CMD_STOP:
            begin
                if (stage == 3'd0) op = '{kind: OP_STOP, src: SRC_DATA};
            end
            CMD_WRITE:
            begin
                if (stage == 3'd0) op = '{kind: OP_WRITE, src: SRC_DATA};
            end
            CMD_READ_ACK, CMD_READ_NACK:
            begin
                if (stage == 3'd0) op = '{kind: OP_READ, src: SRC_DATA};
            end
            CMD_REG_WRITE:
            begin
                case (stage)
                    3'd0: op = '{kind: OP_START, src: SRC_DATA};
                    3'd1: op = '{kind: OP_WRITE, src: SRC_ADDR_W};
                    3'd2: op = '{kind: OP_WRITE, src: SRC_REG};
                    3'd3: op = '{kind: OP_WRITE, src: SRC_DATA};
                    3'd4: op = '{kind: OP_STOP, src: SRC_DATA};
                    default: op = '{kind: OP_NONE, src: SRC_DATA};
                endcase
            end
            CMD_REG_READ:
            begin
                case (stage)
                    3'd0: op = '{kind: OP_START, src: SRC_DATA};
                    3'd1: op = '{kind: OP_WRITE, src: SRC_ADDR_W};
                    3'd2: op = '{kind: OP_WRITE, src: SRC_REG};
                    3'd3: op = '{kind: OP_START, src: SRC_DATA};
                    3'd4: op = '{kind: OP_WRITE, src: SRC_ADDR_R};
                    3'd5: op = '{kind: OP_READ, src: SRC_DATA};
                    3'd6: op = '{kind: OP_STOP, src: SRC_DATA};
                    default: op = '{kind: OP_NONE, src: SRC_DATA};
                endcase
            end
            default:
            begin
                case (stage)
                    3'd0: op = '{kind: OP_START, src: SRC_DATA};
                    3'd1: op = '{kind: OP_WRITE, src: SRC_ADDR_W};
                    3'd2: op = '{kind: OP_WRITE, src: SRC_REG};
                    3'd3: op = '{kind: OP_STOP, src: SRC_DATA};
                    3'd4: op = '{kind: OP_START, src: SRC_DATA};
                    3'd5: op = '{kind: OP_WRITE, src: SRC_ADDR_R};
                    3'd6: op = '{kind: OP_READ, src: SRC_DATA};
                    3'd7: op = '{kind: OP_STOP, src: SRC_DATA};
                    default: op = '{kind: OP_NONE, src: SRC_DATA};
                endcase
            end
        endcase
        return op;
    endfunction

    function automatic logic [4:0] i2cm_op_len(op_kind_t kind);
        logic [4:0] len;
        case (kind)
            OP_START: len = START_STEPS;
            OP_STOP:  len = STOP_STEPS;
            default:  len = BYTE_STEPS;
        endcase
        return len;
    endfunction

    // Pin and data changes at the end of phase k of an operation.
    function automatic dp_t i2cm_act(op_kind_t kind, logic [4:0] k, logic sda_in,
                                     logic [2:0] acmd, dp_t s);
        dp_t        r;
        logic [3:0] b;
        logic [3:0] b2;
        logic       rd;
        logic       rd2;
        r   = s;
        b   = k[4:1] - 4'd1;
        b2  = k[4:1];
        rd  = (kind == OP_READ) ? (b < ACK_BIT) : (b == ACK_BIT);
        rd2 = (kind == OP_READ) ? (b2 < ACK_BIT) : (b2 == ACK_BIT);
        if (kind == OP_START)
        begin
            case (k)
                5'd1:
                begin
                    r.pins.scl_en = 1'b1;
                    r.pins.sda_en = 1'b1;
                    r.pins.sda    = 1'b1;
                end
                5'd2: r.pins.scl = 1'b1;
                5'd3: r.pins.sda = 1'b0;
                5'd4: r.pins.scl = 1'b0;
                default: r = s;
            endcase
        end
        else if (kind == OP_STOP)
        begin
            case (k)
                5'd0: r.pins.sda    = 1'b0;
                5'd1: r.pins.scl    = 1'b1;
                5'd2: r.pins.sda    = 1'b1;
                5'd3: r.pins.sda_en = 1'b0;
                default: r = s;
            endcase
        end
        else if (k[0])
        begin
            r.pins.scl = 1'b1;
        end
        else
        begin
            if (k != 5'd0)
            begin
                // Falling SCL edge; a bit read from the target is sampled here.
                if (rd)
                begin
                    if (b == ACK_BIT)
                    begin
                        r.nack = r.nack | sda_in;
                    end
                    else
                    begin
                        r.shift = {r.shift[6:0], sda_in};
                    end
                    r.pins.sda_en = 1'b1;
                end
                r.pins.scl = 1'b0;
                if (kind == OP_READ && k == BYTE_STEPS)
                begin
                    r.rx = r.shift;
                end
            end
            if (k < BYTE_STEPS)
            begin
                // Set up SDA for the next bit while SCL is low.
                if (rd2)
                begin
                    r.pins.sda    = 1'b1;
                    r.pins.sda_en = 1'b0;
                end
                else if (kind == OP_WRITE)
                begin
                    r.pins.sda = (r.shift & (MSB_MASK >> b2)) != 8'd0;
                end
                else
                begin
                    r.pins.sda = (acmd != CMD_READ_ACK);
                end
            end
        end
        return r;
    endfunction

    // Start of an operation: clear the phase counters, load the byte to send
    // and apply the phase zero action.
    function automatic seq_t i2cm_begin_op(seq_t s, op_t op);
        seq_t r;
        r      = s;
        r.step = 5'd0;
        r.tick = 16'd0;
        if (op.kind == OP_WRITE)
        begin
            case (op.src)
                SRC_DATA:   r.dp.shift = s.data;
                SRC_ADDR_W: r.dp.shift = {s.addr, 1'b0};
                SRC_REG:    r.dp.shift = s.reg_idx;
                default:    r.dp.shift = {s.addr, 1'b0} | READ_FLAG;
            endcase
        end
        else if (op.kind == OP_READ)
        begin
            r.dp.shift = 8'd0;
        end
        r.dp = i2cm_act(op.kind, 5'd0, 1'b0, r.acmd, r.dp);
        return r;
    endfunction

endpackage

// ===== hw/rtl/i2cm_ifs.sv =====
// ============================================================================
// I2C master sequencer channels
// Request, result and configuration write channels with valid and ready.
// ============================================================================
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [2:0] command;
    logic [6:0] dev_addr;
    logic [7:0] reg_index;
    logic [7:0] data_byte;
    logic       sda_in;

    modport source (output valid, req_type, command, dev_addr, reg_index, data_byte,
                    sda_in, input ready);
    modport sink (input valid, req_type, command, dev_addr, reg_index, data_byte,
                  sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       scl_enable;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic       rejected;

    modport source (output valid, scl_out, scl_enable, sda_out, sda_enable, busy_res,
                    done_res, nack_seen, rx_byte, rejected, input ready);
    modport sink (input valid, scl_out, scl_enable, sda_out, sda_enable, busy_res,
                  done_res, nack_seen, rx_byte, rejected, output ready);
endinterface

interface i2cm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [i2cm_pkg::CFG_IDX_W-1:0]     idx;
    logic [i2cm_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, idx, wdata, input ready);
    modport sink (input valid, idx, wdata, output ready);
endinterface

// ===== hw/rtl/i2cm_step.sv =====
// ============================================================================
// I2C master sequencer step logic
// Next sequencer state and result for one request, in a single pass.
// ============================================================================
module i2cm_step (
    input  i2cm_pkg::req_t  req_in,
    input  i2cm_pkg::seq_t  state,
    input  i2cm_pkg::cfg_t  cfg,
    output i2cm_pkg::seq_t  state_next,
    output i2cm_pkg::res_t  res_out
);

    i2cm_pkg::seq_t nx;
    i2cm_pkg::op_t  op_cur;
    i2cm_pkg::op_t  op_nxt;
    i2cm_pkg::op_t  op_first;
    logic [2:0]     row;
    logic [2:0]     stage_inc;
    logic [15:0]    limit;
    logic [15:0]    tick_inc;
    logic [4:0]     k;
    logic           done;
    logic           rej;

    always_comb
    begin
        nx        = state;
        done      = 1'b0;
        rej       = 1'b0;
        row       = i2cm_pkg::i2cm_row(state.acmd, cfg.stop_before_restart);
        stage_inc = state.stage + 3'd1;
        op_cur    = i2cm_pkg::i2cm_op_at(row, state.stage);
        op_nxt    = i2cm_pkg::i2cm_op_at(row, stage_inc);
        op_first  = i2cm_pkg::i2cm_op_at(
                        i2cm_pkg::i2cm_row(req_in.command, cfg.stop_before_restart), 3'd0);
        limit     = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
        tick_inc  = state.tick + 16'd1;
        k         = state.step + 5'd1;

        if (req_in.req_type)
        begin
            if (state.active || req_in.command > i2cm_pkg::CMD_REG_READ)
            begin
                rej = 1'b1;
            end
            else
            begin
                nx.active  = 1'b1;
                nx.acmd    = req_in.command;
                nx.addr    = req_in.dev_addr;
                nx.reg_idx = req_in.reg_index;
                nx.data    = req_in.data_byte;
                nx.stage   = 3'd0;
                if (req_in.command inside {i2cm_pkg::CMD_START, i2cm_pkg::CMD_REG_WRITE,
                                           i2cm_pkg::CMD_REG_READ})
                begin
                    nx.dp.nack = 1'b0;
                end
                nx = i2cm_pkg::i2cm_begin_op(nx, op_first);
            end
        end
        else if (state.active)
        begin
            nx.tick = tick_inc;
            if (tick_inc >= limit)
            begin
                nx.tick = 16'd0;
                nx.step = k;
                nx.dp   = i2cm_pkg::i2cm_act(op_cur.kind, k, req_in.sda_in,
                                             state.acmd, state.dp);
                if (k >= i2cm_pkg::i2cm_op_len(op_cur.kind))
                begin
                    if (state.stage == i2cm_pkg::STAGE_LAST ||
                        op_nxt.kind == i2cm_pkg::OP_NONE)
                    begin
                        nx.active = 1'b0;
                        nx.step   = 5'd0;
                        nx.stage  = 3'd0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        nx.stage = stage_inc;
                        nx = i2cm_pkg::i2cm_begin_op(nx, op_nxt);
                    end
                end
            end
        end
    end

    assign state_next = nx;

    assign res_out = '{
        scl_out:    nx.dp.pins.scl,
        scl_enable: nx.dp.pins.scl_en,
        sda_out:    nx.dp.pins.sda,
        sda_enable: nx.dp.pins.sda_en,
        busy_res:   nx.active,
        done_res:   done,
        nack_seen:  nx.dp.nack,
        rx_byte:    nx.dp.rx,
        rejected:   rej
    };

endmodule

// ===== hw/rtl/i2cm_res_stage.sv =====
// ============================================================================
// I2C master sequencer result register
// Holds one result until the sink takes it; refills in the same cycle.
// ============================================================================
module i2cm_res_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  i2cm_pkg::res_t   res_in,
    output logic             can_load,
    i2cm_res_if.source       res
);

    logic            valid_reg;
    logic            valid_next;
    i2cm_pkg::res_t  data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign can_load       = !valid_reg || res.ready;
    assign res.valid      = valid_reg;
    assign res.scl_out    = data_reg.scl_out;
    assign res.scl_enable = data_reg.scl_enable;
    assign res.sda_out    = data_reg.sda_out;
    assign res.sda_enable = data_reg.sda_enable;
    assign res.busy_res   = data_reg.busy_res;
    assign res.done_res   = data_reg.done_res;
    assign res.nack_seen  = data_reg.nack_seen;
    assign res.rx_byte    = data_reg.rx_byte;
    assign res.rejected   = data_reg.rejected;

endmodule

// ===== hw/rtl/i2c_master_sequencer_unit.sv =====
// ============================================================================
// I2C master sequencer
// Tick-driven I2C master. A command request (req_type 1) is taken while the
// block is idle: START, STOP, write byte, read byte with ACK or NACK, a
// one-byte register write or a one-byte register read; a command that comes
// while busy, or an unused command code, is ignored and flagged as rejected.
// Tick requests (req_type 0) then move the command forward one bit-delay
// phase per phase_ticks ticks, setting SCL, SDA and their enables and
// sampling sda_in on the tick that ends a read phase. Bytes go MSB first and
// every acknowledge bit read is ORed into nack_seen, which is cleared when a
// START, register write or register read command is accepted. Every request
// gives exactly one result, with the pin levels after it, busy, done, the
// NACK flag and the last byte read. A request is taken every clock cycle:
// the whole update is one pass of logic from the held state into a result
// register, which appears in the cycle after acceptance and frees itself in the
// cycle it is taken, so only a stalled result sink slows the stream.
// Configuration writes are always accepted; change them only while idle.
// ============================================================================
module i2c_master_sequencer_unit (
    input  logic          clk,
    input  logic          rst_n,
    i2cm_cfg_if.sink      cfg,
    i2cm_req_if.sink      req,
    i2cm_res_if.source    res
);

    // Configuration registers.
    logic [15:0]     phase_ticks_reg;
    logic            stop_restart_reg;

    // Sequencer state, updated on every accepted request.
    i2cm_pkg::seq_t  state_reg;
    i2cm_pkg::seq_t  state_next;

    i2cm_pkg::req_t  req_in;
    i2cm_pkg::res_t  res_next;
    i2cm_pkg::cfg_t  cfg_cur;
    logic            can_load;
    logic            accept;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg  <= 16'd1;
            stop_restart_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.idx == i2cm_pkg::CFG_PHASE_TICKS)
            begin
                phase_ticks_reg <= cfg.wdata;
            end
            else if (cfg.idx == i2cm_pkg::CFG_STOP_RESTART)
            begin
                stop_restart_reg <= cfg.wdata[0];
            end
        end
    end

    assign cfg_cur = '{phase_ticks: phase_ticks_reg,
                       stop_before_restart: stop_restart_reg};

    assign req_in = '{
        req_type:  req.req_type,
        command:   req.command,
        dev_addr:  req.dev_addr,
        reg_index: req.reg_index,
        data_byte: req.data_byte,
        sda_in:    req.sda_in
    };

    // A request is taken whenever the result register has room for its result.
    assign req.ready = can_load;
    assign accept    = req.valid && can_load;

    i2cm_step u_step (
        .req_in     (req_in),
        .state      (state_reg),
        .cfg        (cfg_cur),
        .state_next (state_next),
        .res_out    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2cm_pkg::SEQ_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    i2cm_res_stage u_res_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res_in   (res_next),
        .can_load (can_load),
        .res      (res)
    );

endmodule
